// File: hdl/b64e_pkg.sv
// Package for the streaming Base64 encoder: group record, queue status,
// character constants and the sextet-to-character lookup.
// No dependencies.
package b64e_pkg;

   localparam int B64E_QUEUE_DEPTH = 2;

   // ASCII codes
   localparam logic [7:0] CHAR_PAD      = 8'h3D;  // '='
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_PLUS     = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH    = 8'h2F;  // '/'
   localparam logic [7:0] CHAR_MINUS    = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_UNDER    = 8'h5F;  // '_'

   // Register indexes on the CSR port
   localparam logic [0:0] CSR_IDX_ALT_ALPHABET = 1'b0;

   // One group of up to three bytes, ready for encoding
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] nbytes;   // 1..3 bytes carried
      logic       eos;      // group closes the stream
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] b64e_symbol(input logic [5:0] sextet, input logic alt_sel);
      logic [7:0] v;
      logic [7:0] ch;
      v = {2'b00, sextet};
      if (sextet < 6'd26) begin
         ch = CHAR_UPPER_A + v;
      end else if (sextet < 6'd52) begin
         ch = CHAR_LOWER_A + v - 8'd26;
      end else if (sextet < 6'd62) begin
         ch = CHAR_DIGIT_0 + v - 8'd52;
      end else if (sextet == 6'd62) begin
         ch = alt_sel ? CHAR_MINUS : CHAR_PLUS;
      end else begin
         ch = alt_sel ? CHAR_UNDER : CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

// File: hdl/b64e_front.sv
// Front end: accepts byte transactions, holds up to two pending bytes and
// pushes complete or padded groups into the queue. Uses b64e_pkg.
module b64e_front import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_has_byte,
   input  logic [7:0]   req_data_byte,
   input  logic         req_end_of_stream,
   input  q_status_type q_status,
   output logic         push,
   output group_type    push_group
);

   logic [1:0] count_ff, count_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic [1:0] cnt;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cnt        = (count_ff == 2'd3) ? 2'd2 : count_ff;
      count_in   = count_ff;
      pend0_in   = pend0_ff;
      pend1_in   = pend1_ff;
      push       = 1'b0;
      push_group = '{byte0: pend0_ff, byte1: pend1_ff, byte2: req_data_byte,
                     nbytes: 2'd3, eos: req_end_of_stream};
      if (accept) begin
         if (req_has_byte && cnt == 2'd2) begin
            push     = 1'b1;
            count_in = 2'd0;
         end else begin
            if (req_has_byte) begin
               if (cnt == 2'd0) begin
                  pend0_in = req_data_byte;
               end else begin
                  pend1_in = req_data_byte;
               end
               cnt = cnt + 2'd1;
            end
            count_in = cnt;
            if (req_end_of_stream && cnt != 2'd0) begin
               // pad the partial group; unused bytes read as zero
               push              = 1'b1;
               push_group.byte0  = pend0_in;
               push_group.byte1  = (cnt == 2'd2) ? pend1_in : 8'd0;
               push_group.byte2  = 8'd0;
               push_group.nbytes = cnt;
               push_group.eos    = 1'b1;
               count_in          = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("pending count out of range");

endmodule

// File: hdl/b64e_queue.sv
// Short group queue between front and back end.
// Uses b64e_pkg for the group record and status struct.
module b64e_queue import b64e_pkg::*; #(
   parameter int DEPTH = B64E_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  group_type    push_group,
   input  logic         pop,
   output group_type    head,
   output q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = entries_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("group pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

endmodule

// File: hdl/b64e_back.sv
// Back end: turns the head group into four characters, one per cycle while
// the response is not stalled, into the registered result stage. Uses b64e_pkg.
module b64e_back import b64e_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         alt_alphabet,
   input  group_type    head,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_char,
   output logic         rsp_last_of_run,
   output logic         rsp_stream_done
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       load;
   logic [5:0] sextet;
   logic       pad;

   assign load = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      pad = 1'b0;
      case (idx_ff)
         2'd0: sextet = head.byte0[7:2];
         2'd1: sextet = {head.byte0[1:0], head.byte1[7:4]};
         2'd2: begin
            sextet = {head.byte1[3:0], head.byte2[7:6]};
            pad    = (head.nbytes < 2'd2);
         end
         2'd3: begin
            sextet = head.byte2[5:0];
            pad    = (head.nbytes < 2'd3);
         end
         default: sextet = '0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         char_in  = pad ? CHAR_PAD : b64e_symbol(sextet, alt_alphabet);
         last_in  = (idx_ff == 2'd3);
         done_in  = (idx_ff == 2'd3) && head.eos;
         idx_in   = idx_ff + 2'd1;
         pop      = (idx_ff == 2'd3);
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_stream_done = done_ff;

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !q_status.empty)
      else $error("group left queue mid-encode");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> last_ff)
      else $error("stream_done without last_of_run");

endmodule

// File: hdl/base64_stream_encoder_unit.sv
// Top level of the streaming Base64 encoder: CSR port, front end, group
// queue and back end. Uses b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+----------------------------------
//  request  | req_valid / req_stall          | one byte and/or end mark per transaction
//  response | rsp_valid / rsp_stall          | one character per transaction
//  csr      | psel penable pwrite paddr ...  | alphabet select at byte address 0
//
// The front end takes one request per cycle while the queue has room; a
// group of three bytes leaves as four characters, so the back end's
// one-character-per-cycle output stage, when the response is not stalled,
// sets the sustained rate. Reset (synchronous) empties the queue, clears the
// pending count and selects the standard alphabet. req_stall is high only
// while the group queue is full; a stalled response holds in its register.
module base64_stream_encoder_unit import b64e_pkg::*; #(
   parameter int QUEUE_DEPTH = B64E_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   // response transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_of_run,
   output logic        rsp_stream_done,
   // CSR port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic         alt_alphabet_ff, alt_alphabet_in;
   logic         csr_hit;
   q_status_type q_status;
   logic         push;
   group_type    push_group;
   logic         pop;
   group_type    head;

   // CSR: single register, word address paddr[2]
   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == CSR_IDX_ALT_ALPHABET);

   always_comb begin
      alt_alphabet_in = alt_alphabet_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         alt_alphabet_in = pwdata[0];
      end
   end

   assign prdata = csr_hit ? {31'd0, alt_alphabet_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_alphabet_ff <= 1'b0;
      end else begin
         alt_alphabet_ff <= alt_alphabet_in;
      end
   end

   b64e_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_has_byte      (req_has_byte),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_status          (q_status),
      .push              (push),
      .push_group        (push_group)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   // The user must change the alphabet bit only while idle (the block does not enforce it); the back end reads it live.
   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .alt_alphabet    (alt_alphabet_ff),
      .head            (head),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done)
   );

endmodule

// File: tb/base64_stream_encoder_unit_tb.sv
// Self-checking testbench for base64_stream_encoder_unit: directed and random
// byte streams, both alphabets, random sender gaps and receiver stalls.
// Depends on b64e_pkg and the encoder RTL only.
module base64_stream_encoder_unit_tb;
   import b64e_pkg::*;

   // Run control
   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE_CYCLES = 16;    // queue depth plus output stage, with margin
   localparam int MAX_PRINTED = 40;      // mismatch lines printed, all are counted

   // CSR map: alphabet select is register 0, byte address 4*index
   localparam logic [2:0] ALT_ALPHABET_ADDR = {CSR_IDX_ALT_ALPHABET, 2'b00};

   // Standard alphabet, character k sits at bits [8*(63-k) +: 8]
   localparam logic [8*64-1:0] STD_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // One request transaction as queued for the driver
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_stream;
      logic       drain_first;   // hold it back until every due character has come
   } stream_item_type;

   // One response transaction as predicted
   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       stream_done;
   } enc_char_type;

   // Clock, reset and DUT ports; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_has_byte = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_of_run;
   logic        rsp_stream_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // Encoder shadow state: alphabet select, bytes held back, their count
   logic        alt_alphabet_sel = 1'b0;
   logic [7:0]  held_bytes [2] = '{8'h00, 8'h00};
   int          held_count = 0;

   stream_item_type stream_items [$];   // request transactions not yet offered
   enc_char_type    due_chars [$];      // characters predicted, oldest first

   int error_count = 0;
   int cycle_count = 0;

   // Driver and receiver bookkeeping
   stream_item_type nxt;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int stall_tick = 0;
   enc_char_type got;
   enc_char_type want;

   base64_stream_encoder_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_has_byte      (req_has_byte),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_stream_done   (rsp_stream_done),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Sextet to character under the current alphabet select
   function automatic logic [7:0] sextet_char(input logic [5:0] k);
      if (alt_alphabet_sel && k == 6'd62) return CHAR_MINUS;
      if (alt_alphabet_sel && k == 6'd63) return CHAR_UNDER;
      return STD_ALPHABET[8*(63-k) +: 8];
   endfunction

   // Shadow of the encoder for one accepted transaction. A third byte closes
   // a group of 24 bits; an end mark pads whatever is held with zero bits and
   // '=' characters. A byte that closes a group and also ends the stream
   // pads nothing. Flags go on the fourth character only.
   task automatic encode_item(input logic has, input logic [7:0] data, input logic eos);
      logic [7:0] g0;
      logic [7:0] g1;
      logic [7:0] g2;
      logic [7:0] c [4];
      int         n;
      int         cnt;
      g0 = 8'h00;
      g1 = 8'h00;
      g2 = 8'h00;
      n = 0;
      cnt = held_count;
      if (has) begin
         if (cnt == 2) begin
            g0 = held_bytes[0];
            g1 = held_bytes[1];
            g2 = data;
            n = 3;
            cnt = 0;
         end else begin
            held_bytes[cnt] = data;
            cnt++;
         end
      end
      if (eos && cnt > 0) begin
         g0 = held_bytes[0];
         g1 = (cnt > 1) ? held_bytes[1] : 8'h00;
         g2 = 8'h00;
         n = cnt;
         cnt = 0;
      end
      held_count = cnt;
      if (n > 0) begin
         c[0] = sextet_char(g0[7:2]);
         c[1] = sextet_char({g0[1:0], g1[7:4]});
         c[2] = (n > 1) ? sextet_char({g1[3:0], g2[7:6]}) : CHAR_PAD;
         c[3] = (n > 2) ? sextet_char(g2[5:0]) : CHAR_PAD;
         for (int i = 0; i < 4; i++)
            due_chars.insert(due_chars.size(),
                             enc_char_type'{c[i], (i == 3), (i == 3) && eos});
      end
   endtask

   // Queue one request transaction; returns 1 if it does anything to the block
   function automatic int add_item(input logic has, input logic [7:0] data,
                                   input logic eos, input logic hold);
      stream_items.insert(stream_items.size(), stream_item_type'{has, data, eos, hold});
      return (has || eos) ? 1 : 0;
   endfunction

   // Wait until nothing is queued, offered or due, then let empty
   // transactions still inside the block drain out.
   task automatic wait_idle();
      @(negedge clock);
      while (stream_items.size() != 0 || req_valid || due_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Alphabet change only with the block idle; read back what was written
   task automatic set_alphabet(input logic alt_sel);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, ALT_ALPHABET_ADDR, {31'b0, alt_sel}, rd);
      alt_alphabet_sel = alt_sel;
      csr_access(1'b0, ALT_ALPHABET_ADDR, 32'h0, rd);
      if (rd[0] !== alt_sel)
         report_mismatch($sformatf("alphabet select reads %b, wrote %b", rd[0], alt_sel));
   endtask

   // Mostly well-formed streams of random bytes, some ending on the last
   // byte and some on a flush-only end mark, sprinkled with empty
   // transactions; about one in five is plain noise.
   task automatic add_random_streams(input int n_items);
      int counted;
      int len;
      logic eos_on_byte;
      counted = 0;
      while (counted < n_items) begin
         if ($urandom_range(0, 4) == 0) begin
            counted += add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            eos_on_byte = (len > 0) && ($urandom_range(0, 1) != 0);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)
                  void'(add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0));
               counted += add_item(1'b1, 8'($urandom_range(0, 255)),
                                   eos_on_byte && (k == len - 1),
                                   $urandom_range(0, 49) == 0);
            end
            if (!eos_on_byte)
               counted += add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end
      end
   endtask

   // Sender: bursts of random length with random gaps. Prediction runs at
   // the edge where a transaction is taken, from the values that were on
   // the port. A stalled transaction holds its payload; valid only drops
   // after an acceptance or while idle, never because of stall.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            encode_item(req_has_byte, req_data_byte, req_end_of_stream);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (stream_items.size() != 0 &&
                         !(stream_items[0].drain_first && due_chars.size() != 0)) begin
               nxt = stream_items.pop_front();
               req_valid <= 1'b1;
               req_has_byte <= nxt.has_byte;
               req_data_byte <= nxt.data_byte;
               req_end_of_stream <= nxt.end_of_stream;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     7:       gap_left = $urandom_range(8, 20);
                     default: gap_left = $urandom_range(1, 4);
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall in modes that each last a while (none, random, a fixed
   // one-in-three beat, heavy) and check every character taken against
   // the oldest one due.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_char, rsp_last_of_run, rsp_stream_done};
            if (due_chars.size() == 0) begin
               report_mismatch($sformatf("character %h with none due", rsp_out_char));
            end else begin
               want = due_chars.pop_front();
               if (got.out_char !== want.out_char)
                  report_mismatch($sformatf("out_char %h, want %h",
                                            got.out_char, want.out_char));
               if (got.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, want %b",
                                            got.last_of_run, want.last_of_run));
               if (got.stream_done !== want.stream_done)
                  report_mismatch($sformatf("stream_done %b, want %b",
                                            got.stream_done, want.stream_done));
            end
         end
         if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) != 0);
            2:       rsp_stall <= (stall_tick % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Phases: each alphabet change waits for an idle block
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, standard alphabet
      set_alphabet(1'b0);
      void'(add_item(1'b0, 8'hA5, 1'b0, 1'b0));  // empty transaction: nothing out
      void'(add_item(1'b0, 8'h5A, 1'b1, 1'b0));  // end with nothing held: nothing out
      void'(add_item(1'b1, 8'h00, 1'b0, 1'b0));  // all-zero group: AAAA
      void'(add_item(1'b1, 8'h00, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'h00, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hFF, 1'b0, 1'b0));  // all-ones group, closing byte ends stream
      void'(add_item(1'b1, 8'hFF, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hFF, 1'b1, 1'b0));
      void'(add_item(1'b1, 8'h80, 1'b1, 1'b0));  // single byte with end mark: two pads
      void'(add_item(1'b1, 8'h7F, 1'b0, 1'b0));  // single byte, flush-only end
      void'(add_item(1'b0, 8'h00, 1'b0, 1'b0));
      void'(add_item(1'b0, 8'hFF, 1'b1, 1'b0));
      void'(add_item(1'b1, 8'hFB, 1'b0, 1'b0));  // two bytes, end on the second: one pad
      void'(add_item(1'b1, 8'hEF, 1'b1, 1'b0));
      void'(add_item(1'b1, 8'hFB, 1'b0, 1'b1));  // sextet 62 four times, after a drain
      void'(add_item(1'b1, 8'hEF, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hBE, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'h01, 1'b0, 1'b0));  // empty transaction between held bytes
      void'(add_item(1'b0, 8'h00, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'h02, 1'b1, 1'b0));
      void'(add_item(1'b0, 8'h00, 1'b1, 1'b0));  // count was cleared: nothing out

      // URL-safe alphabet on the two characters that differ
      set_alphabet(1'b1);
      void'(add_item(1'b1, 8'hFB, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hEF, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hBE, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hFF, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hFF, 1'b0, 1'b0));
      void'(add_item(1'b1, 8'hFF, 1'b1, 1'b0));
      add_random_streams(60);

      set_alphabet(1'b0);
      add_random_streams(90);
      set_alphabet(1'b1);
      add_random_streams(90);
      set_alphabet(1'b1);     // same value again
      add_random_streams(40);
      set_alphabet(1'b0);
      add_random_streams(70);

      wait_idle();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
